// ===== rtl/core/pwi_pkg.sv =====
// ----------------------------------------------------------------------------
// pwi_pkg: shared types and constants of the windowed-integral PID regulator
// Q16.16 data types, register indexes, operation codes and datapath sizes.
// ----------------------------------------------------------------------------
package pwi_pkg;

    localparam int DATA_W     = 32;   // Q16.16 word
    localparam int FRAC_W     = 16;   // fraction bits of Q16.16
    localparam int DIG_W      = 16;   // multiplier digit width
    localparam int PRODUCT_W  = 48;   // stored error*time_step, Q32.16
    localparam int MAG_W      = 48;   // |error difference| << 16
    localparam int DIV_BITS   = 2;    // quotient bits per divider cycle
    localparam int DIV_CYCLES = MAG_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam int LEN_CFG_W  = 5;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic        [DATA_W-1:0] uq16_t;
    typedef logic        [1:0]        cfg_index_t;
    typedef logic        [LEN_CFG_W-1:0] win_len_t;

    localparam cfg_index_t REG_P_GAIN     = 2'd0;
    localparam cfg_index_t REG_I_GAIN     = 2'd1;
    localparam cfg_index_t REG_D_GAIN     = 2'd2;
    localparam cfg_index_t REG_WINDOW_LEN = 2'd3;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam win_len_t WIN_LEN_RESET = 5'd16;
    localparam win_len_t WIN_LEN_MIN   = 5'd3;

    localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q16_MIN = 32'sh8000_0000;

endpackage

// ===== rtl/core/pwi_ram.sv =====
// ----------------------------------------------------------------------------
// pwi_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module pwi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== rtl/core/pid_windowed_integral.sv =====
// ----------------------------------------------------------------------------
// pid_windowed_integral: PID regulator with a sliding-window integral
// drive = P*error + I*window_sum + D*(error change / time_step), Q16.16,
// floored and saturated to 32 bits. One shared 33x17 multiplier, a radix-4
// serial divider and a ring of products in RAM.
//
//   channel  | dir | handshake            | contents
//   ---------+-----+----------------------+----------------------------------
//   s_*      | in  | s_valid / s_ready    | operation, error_in, time_step
//   m_*      | out | m_valid / m_ready    | drive, zero_step
//   cfg_*    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// A step transaction runs four 4-digit multiplier passes, error*time_step,
// P, I and D, beside the derivative divider that starts at accept; the D pass
// waits for the divider, and a zero time step skips the divider.
// A clear transaction, a window_len write and reset sweep all WINDOW_MAX ring
// slots with s_ready low. A finished result waits in the output register;
// a stalled m_ready holds the block only once a second result is due.
// ----------------------------------------------------------------------------
module pid_windowed_integral #(
    parameter int WINDOW_MAX = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // step / clear transactions
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  pwi_pkg::q16_t           s_error_in,
    input  pwi_pkg::uq16_t          s_time_step,
    // results
    output logic                    m_valid,
    input  logic                    m_ready,
    output pwi_pkg::q16_t           m_drive,
    output logic                    m_zero_step,
    // register writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  pwi_pkg::cfg_index_t     cfg_index,
    input  pwi_pkg::uq16_t          cfg_data
);
    import pwi_pkg::*;

    localparam int SLOT_W    = $clog2(WINDOW_MAX);
    localparam int LEN_W     = (SLOT_W + 1 > LEN_CFG_W) ? SLOT_W + 1 : LEN_CFG_W;
    localparam int SUM_W     = PRODUCT_W + SLOT_W + 1;
    localparam int DER_W     = MAG_W + 1;
    localparam int OPB_MIN   = (SUM_W > DER_W) ? SUM_W : DER_W;
    localparam int BW        = ((OPB_MIN + DIG_W - 1) / DIG_W) * DIG_W;
    localparam int NDIG      = BW / DIG_W;
    localparam int DIG_CNT_W = $clog2(NDIG);
    localparam int A_W       = DATA_W + 1;
    localparam int PP_W      = A_W + DIG_W + 1;
    localparam int PROD_W    = A_W + BW;
    localparam int TOT_W     = PROD_W + 2;
    localparam int SAT_BIT   = DATA_W + FRAC_W - 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [1:0] PH_ED = 2'd0;   // error * time_step
    localparam logic [1:0] PH_P  = 2'd1;
    localparam logic [1:0] PH_I  = 2'd2;
    localparam logic [1:0] PH_D  = 2'd3;

    // control
    logic [2:0]             state_reg, state_next;
    logic [1:0]             phase_reg, phase_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [SLOT_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   div_busy_reg, div_busy_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   m_valid_reg, m_valid_next;

    // history and configuration
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    q16_t                    last_err_reg, last_err_next;
    q16_t                    p_gain_reg, p_gain_next;
    q16_t                    i_gain_reg, i_gain_next;
    q16_t                    d_gain_reg, d_gain_next;
    win_len_t                win_len_reg, win_len_next;

    // datapath
    q16_t                     err_reg, err_next;
    uq16_t                    dt_reg, dt_next;
    logic                     zero_reg, zero_next;
    logic                     dneg_reg, dneg_next;
    logic [DATA_W-1:0]        rem_reg, rem_next;
    logic [MAG_W-1:0]         dvd_reg, dvd_next;
    logic signed [A_W-1:0]    a_reg, a_next;
    logic [BW-1:0]            b_reg, b_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [TOT_W-1:0]  total_reg, total_next;
    q16_t                     m_drive_reg, m_drive_next;
    logic                     m_zero_step_reg, m_zero_step_next;

    // ring memory
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [PRODUCT_W-1:0]  ram_wdata;
    logic                  ram_re;
    logic [PRODUCT_W-1:0]  ram_rdata;

    // combinational helpers
    logic                     s_fire, step_fire, len_write;
    logic [DIG_W-1:0]         digit_top;
    logic                     first_dig;
    logic signed [DIG_W:0]    dig_ext;
    logic signed [PP_W-1:0]   pp;
    logic signed [PROD_W-1:0] pp_ext, prod_step;
    logic signed [A_W-1:0]    diff;
    logic [A_W-1:0]           diff_mag;
    logic [DATA_W:0]          div_rem_w, div_trial;
    logic [MAG_W-1:0]         div_dvd_w;
    logic                     div_ge;
    logic signed [DER_W-1:0]  deriv_mag, deriv;
    logic [LEN_W-1:0]         win_ext, len_eff;
    logic [SLOT_W:0]          slot_inc;
    logic signed [PRODUCT_W-1:0] product;
    logic signed [TOT_W-1:0]  total_acc;
    logic                     sat_ones, sat_zeros;
    q16_t                     drive_sat;

    pwi_ram #(
        .WIDTH (PRODUCT_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (slot_reg),
        .rd_data (ram_rdata)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_drive     = m_drive_reg;
    assign m_zero_step = m_zero_step_reg;

    assign s_fire    = s_valid && s_ready;
    assign step_fire = s_fire && (s_operation == OP_STEP);
    assign len_write = cfg_valid && (cfg_index == REG_WINDOW_LEN);
    assign ram_re    = step_fire;

    // shared multiplier: Horner over digits of b, most significant first
    assign digit_top = b_reg[BW-1 -: DIG_W];
    assign first_dig = (dig_cnt_reg == DIG_CNT_W'(NDIG - 1));
    assign dig_ext   = {first_dig & digit_top[DIG_W-1], digit_top};
    assign pp        = PP_W'(a_reg) * PP_W'(dig_ext);
    assign pp_ext    = {{(PROD_W - PP_W){pp[PP_W-1]}}, pp};
    assign prod_step = first_dig ? pp_ext : (prod_reg <<< DIG_W) + pp_ext;

    assign diff     = {s_error_in[DATA_W-1], s_error_in}
                    - {last_err_reg[DATA_W-1], last_err_reg};
    assign diff_mag = diff[A_W-1] ? A_W'(-diff) : A_W'(diff);

    // divider: DIV_BITS restoring steps per cycle
    always_comb begin
        div_rem_w = {1'b0, rem_reg};
        div_dvd_w = dvd_reg;
        div_trial = '0;
        div_ge    = 1'b0;
        for (int i = 0; i < DIV_BITS; i++) begin
            div_trial = {div_rem_w[DATA_W-1:0], div_dvd_w[MAG_W-1]};
            div_ge    = (div_trial >= {1'b0, dt_reg});
            div_rem_w = div_ge ? div_trial - {1'b0, dt_reg} : div_trial;
            div_dvd_w = {div_dvd_w[MAG_W-2:0], div_ge};
        end
    end

    assign deriv_mag = {1'b0, dvd_reg};
    assign deriv     = dneg_reg ? -deriv_mag : deriv_mag;

    always_comb begin
        win_ext = LEN_W'(win_len_reg);
        if (win_ext < LEN_W'(WIN_LEN_MIN)) begin
            len_eff = LEN_W'(WIN_LEN_MIN);
        end else if (win_ext > LEN_W'(WINDOW_MAX)) begin
            len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            len_eff = win_ext;
        end
    end

    assign slot_inc  = {1'b0, slot_reg} + (SLOT_W + 1)'(1);
    assign product   = prod_reg[PRODUCT_W + FRAC_W - 1:FRAC_W];
    assign total_acc = total_reg + {{(TOT_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    assign sat_ones  = &total_reg[TOT_W-1:SAT_BIT];
    assign sat_zeros = ~|total_reg[TOT_W-1:SAT_BIT];
    assign drive_sat = (sat_ones || sat_zeros) ? total_reg[SAT_BIT:FRAC_W]
                     : (total_reg[TOT_W-1] ? Q16_MIN : Q16_MAX);

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        dig_cnt_next     = dig_cnt_reg;
        clr_cnt_next     = clr_cnt_reg;
        slot_next        = slot_reg;
        div_busy_next    = div_busy_reg;
        div_cnt_next     = div_cnt_reg;
        m_valid_next     = m_valid_reg;
        sum_next         = sum_reg;
        last_err_next    = last_err_reg;
        p_gain_next      = p_gain_reg;
        i_gain_next      = i_gain_reg;
        d_gain_next      = d_gain_reg;
        win_len_next     = win_len_reg;
        err_next         = err_reg;
        dt_next          = dt_reg;
        zero_next        = zero_reg;
        dneg_next        = dneg_reg;
        rem_next         = rem_reg;
        dvd_next         = dvd_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        prod_next        = prod_reg;
        total_next       = total_reg;
        m_drive_next     = m_drive_reg;
        m_zero_step_next = m_zero_step_reg;
        ram_we           = 1'b0;
        ram_waddr        = slot_reg;
        ram_wdata        = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // advance the divider
        if (div_busy_reg) begin
            rem_next = div_rem_w[DATA_W-1:0];
            dvd_next = div_dvd_w;
            if (div_cnt_reg == '0) begin
                div_busy_next = 1'b0;
            end else begin
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
            end
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                if (clr_cnt_reg == SLOT_W'(WINDOW_MAX - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_fire && s_operation == OP_CLEAR) begin
                    sum_next      = '0;
                    last_err_next = '0;
                    slot_next     = '0;
                    clr_cnt_next  = '0;
                    state_next    = ST_CLEAR;
                end else if (s_fire) begin
                    err_next      = s_error_in;
                    dt_next       = s_time_step;
                    zero_next     = (s_time_step == '0);
                    last_err_next = s_error_in;
                    dneg_next     = diff[A_W-1];
                    rem_next      = '0;
                    dvd_next      = (s_time_step == '0) ? '0
                                  : {diff_mag[DATA_W-1:0], {FRAC_W{1'b0}}};
                    div_busy_next = (s_time_step != '0);
                    div_cnt_next  = DIV_CNT_W'(DIV_CYCLES - 1);
                    a_next        = {s_error_in[DATA_W-1], s_error_in};
                    b_next        = {{(BW - DATA_W){1'b0}}, s_time_step};
                    dig_cnt_next  = DIG_CNT_W'(NDIG - 1);
                    phase_next    = PH_ED;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next = prod_step;
                b_next    = b_reg << DIG_W;
                if (dig_cnt_reg == '0) begin
                    state_next = ST_ACC;
                end else begin
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
            end
            ST_ACC: begin
                dig_cnt_next = DIG_CNT_W'(NDIG - 1);
                case (phase_reg)
                    PH_ED: begin
                        // swap the oldest product for the new one
                        sum_next   = sum_reg
                                   + {{(SUM_W - PRODUCT_W){product[PRODUCT_W-1]}}, product}
                                   - {{(SUM_W - PRODUCT_W){ram_rdata[PRODUCT_W-1]}},
                                      ram_rdata};
                        ram_we     = 1'b1;
                        ram_wdata  = product;
                        slot_next  = (LEN_W'(slot_inc) >= len_eff) ? '0
                                   : slot_inc[SLOT_W-1:0];
                        total_next = '0;
                        a_next     = {p_gain_reg[DATA_W-1], p_gain_reg};
                        b_next     = {{(BW - DATA_W){err_reg[DATA_W-1]}}, err_reg};
                        phase_next = PH_P;
                        state_next = ST_MUL;
                    end
                    PH_P: begin
                        total_next = total_acc;
                        a_next     = {i_gain_reg[DATA_W-1], i_gain_reg};
                        b_next     = {{(BW - SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
                        phase_next = PH_I;
                        state_next = ST_MUL;
                    end
                    PH_I: begin
                        total_next = total_acc;
                        phase_next = PH_D;
                        if (div_busy_reg) begin
                            state_next = ST_WAIT;
                        end else begin
                            a_next     = {d_gain_reg[DATA_W-1], d_gain_reg};
                            b_next     = {{(BW - DER_W){deriv[DER_W-1]}}, deriv};
                            state_next = ST_MUL;
                        end
                    end
                    default: begin
                        total_next = total_acc;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WAIT: begin
                if (!div_busy_reg) begin
                    a_next       = {d_gain_reg[DATA_W-1], d_gain_reg};
                    b_next       = {{(BW - DER_W){deriv[DER_W-1]}}, deriv};
                    dig_cnt_next = DIG_CNT_W'(NDIG - 1);
                    state_next   = ST_MUL;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_drive_next     = drive_sat;
                    m_zero_step_next = zero_reg;
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            case (cfg_index)
                REG_P_GAIN: p_gain_next = cfg_data;
                REG_I_GAIN: i_gain_next = cfg_data;
                REG_D_GAIN: d_gain_next = cfg_data;
                REG_WINDOW_LEN: begin
                    win_len_next  = cfg_data[LEN_CFG_W-1:0];
                    sum_next      = '0;
                    last_err_next = '0;
                    slot_next     = '0;
                    clr_cnt_next  = '0;
                    div_busy_next = 1'b0;
                    state_next    = ST_CLEAR;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            phase_reg    <= PH_ED;
            dig_cnt_reg  <= '0;
            clr_cnt_reg  <= '0;
            slot_reg     <= '0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            sum_reg      <= '0;
            last_err_reg <= '0;
            p_gain_reg   <= '0;
            i_gain_reg   <= '0;
            d_gain_reg   <= '0;
            win_len_reg  <= WIN_LEN_RESET;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            dig_cnt_reg  <= dig_cnt_next;
            clr_cnt_reg  <= clr_cnt_next;
            slot_reg     <= slot_next;
            div_busy_reg <= div_busy_next;
            div_cnt_reg  <= div_cnt_next;
            m_valid_reg  <= m_valid_next;
            sum_reg      <= sum_next;
            last_err_reg <= last_err_next;
            p_gain_reg   <= p_gain_next;
            i_gain_reg   <= i_gain_next;
            d_gain_reg   <= d_gain_next;
            win_len_reg  <= win_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg         <= err_next;
        dt_reg          <= dt_next;
        zero_reg        <= zero_next;
        dneg_reg        <= dneg_next;
        rem_reg         <= rem_next;
        dvd_reg         <= dvd_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        prod_reg        <= prod_next;
        total_reg       <= total_next;
        m_drive_reg     <= m_drive_next;
        m_zero_step_reg <= m_zero_step_next;
    end

    // a step transaction starts the multiplier on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && !len_write |=> state_reg == ST_MUL)
        else $error("step transaction did not start the multiplier");

    // the divider has finished whenever the block can take a new transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !div_busy_reg)
        else $error("divider still busy while idle");

    // a result appears only out of the final state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final state");

    // the zero-step flag follows the accepted time step
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> zero_reg == ($past(s_time_step) == '0))
        else $error("zero-step flag does not match the time step");

    // the divider never runs on a zero time step
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy_reg |-> !zero_reg)
        else $error("divider running on a zero time step");

endmodule
